### src/crsf_rcd_pkg.sv
// Shared types and constants for the CRSF RC channel decoder.
package crsf_rcd_pkg;

  localparam int unsigned NumReportedDef = 8;
  localparam int unsigned MaxFrameLenDef = 62;

  localparam logic [7:0]  SyncByte = 8'hC8;
  localparam logic [7:0]  RcType   = 8'h16;
  localparam logic [7:0]  MinLen   = 8'd2;
  localparam int unsigned ChBits   = 11;
  localparam int unsigned AccBits  = 18;
  localparam logic [10:0] MidValue = 11'd992;
  localparam int unsigned DbBits   = 13;
  localparam logic [12:0] DbReset  = 13'd1;

  typedef enum logic [2:0] {
    StHunt,
    StLen,
    StBody,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic start_frame;
    logic body_beat;
    logic walk_clr;
    logic scan_step;
    logic walk_adv;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_ok;
    logic frame_end;
    logic rc_ready;
    logic last_walk;
    logic hit_cur;
    logic out_free;
  } sts_t;

endpackage

### src/crsf_rcd_dp.sv
// Datapath: frame counters, bit unpacker, channel stores and result register.
module crsf_rcd_dp #(
  parameter int unsigned NumReported = crsf_rcd_pkg::NumReportedDef,
  parameter int unsigned MaxFrameLen = crsf_rcd_pkg::MaxFrameLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                dead_band_we_i,
  input  logic [12:0]         dead_band_i,
  input  logic                res_ready_i,
  input  crsf_rcd_pkg::cmd_t  cmd_i,
  output crsf_rcd_pkg::sts_t  sts_o,
  output logic                res_valid_o,
  output logic [2:0]          channel_o,
  output logic [10:0]         value_o,
  output logic                last_o
);

  localparam int unsigned IdxW = (NumReported > 1) ? $clog2(NumReported) : 1;
  localparam int unsigned CntW = $clog2(NumReported + 1);
  localparam int unsigned AccW = crsf_rcd_pkg::AccBits;
  localparam int unsigned ChW  = crsf_rcd_pkg::ChBits;

  logic [12:0]     dead_band_q;
  logic [5:0]      frame_len_q;
  logic [5:0]      bytes_seen_q;
  logic            is_rc_q;
  logic [AccW-1:0] bit_accum_q;
  logic [4:0]      bits_held_q;
  logic [CntW-1:0] unpack_idx_q;
  logic [IdxW-1:0] walk_q;
  logic [ChW-1:0]  fresh_q    [NumReported];
  logic [ChW-1:0]  reported_q [NumReported];
  logic [NumReported-1:0] hit_q;

  logic            out_valid_q;
  logic [2:0]      out_chan_q;
  logic [ChW-1:0]  out_val_q;
  logic            out_last_q;

  logic [4:0]      held_sum;
  logic [AccW-1:0] acc_or;
  logic            take_payload;
  logic [ChW-1:0]  cur_fresh;
  logic [ChW-1:0]  cur_rep;
  logic [ChW-1:0]  diff;
  logic            hit_now;
  logic            higher_hit;
  logic            out_free;

  assign held_sum     = bits_held_q + 5'd8;
  assign acc_or       = bit_accum_q | (AccW'(rx_byte_i) << bits_held_q[3:0]);
  assign take_payload = cmd_i.body_beat && (bytes_seen_q != 6'd0) &&
                        ({1'b0, bytes_seen_q} + 7'd1 < {1'b0, frame_len_q}) &&
                        is_rc_q && (unpack_idx_q < CntW'(NumReported));

  assign cur_fresh = fresh_q[walk_q];
  assign cur_rep   = reported_q[walk_q];
  assign diff      = (cur_fresh > cur_rep) ? (cur_fresh - cur_rep) : (cur_rep - cur_fresh);
  assign hit_now   = {2'b00, diff} > dead_band_q;

  always_comb begin
    higher_hit = 1'b0;
    for (int j = 0; j < NumReported; j++) begin
      if (IdxW'(j) > walk_q) begin
        higher_hit = higher_hit | hit_q[j];
      end
    end
  end

  assign out_free = !out_valid_q || res_ready_i;

  assign sts_o.is_sync   = (rx_byte_i == crsf_rcd_pkg::SyncByte);
  assign sts_o.len_ok    = (rx_byte_i >= crsf_rcd_pkg::MinLen) &&
                           (rx_byte_i <= 8'(MaxFrameLen));
  assign sts_o.frame_end = ({1'b0, bytes_seen_q} + 7'd1 >= {1'b0, frame_len_q});
  assign sts_o.rc_ready  = is_rc_q && (unpack_idx_q == CntW'(NumReported));
  assign sts_o.last_walk = (walk_q == IdxW'(NumReported - 1));
  assign sts_o.hit_cur   = hit_q[walk_q];
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q <= crsf_rcd_pkg::DbReset;
    end else if (dead_band_we_i) begin
      dead_band_q <= dead_band_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q  <= '0;
      bytes_seen_q <= '0;
      is_rc_q      <= 1'b0;
      bit_accum_q  <= '0;
      bits_held_q  <= '0;
      unpack_idx_q <= '0;
    end else if (cmd_i.start_frame) begin
      frame_len_q  <= rx_byte_i[5:0];
      bytes_seen_q <= '0;
      is_rc_q      <= 1'b0;
      bit_accum_q  <= '0;
      bits_held_q  <= '0;
      unpack_idx_q <= '0;
    end else if (cmd_i.body_beat) begin
      bytes_seen_q <= bytes_seen_q + 6'd1;
      if (bytes_seen_q == 6'd0) begin
        is_rc_q <= (rx_byte_i == crsf_rcd_pkg::RcType);
      end
      if (take_payload) begin
        if (held_sum >= 5'(ChW)) begin
          bit_accum_q  <= acc_or >> ChW;
          bits_held_q  <= held_sum - 5'(ChW);
          unpack_idx_q <= unpack_idx_q + CntW'(1);
        end else begin
          bit_accum_q <= acc_or;
          bits_held_q <= held_sum;
        end
      end
    end
  end

  // unpacked channels, valid only once the frame fills them all
  always_ff @(posedge clk_i) begin
    if (take_payload && (held_sum >= 5'(ChW))) begin
      fresh_q[unpack_idx_q[IdxW-1:0]] <= acc_or[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumReported; k++) begin
        reported_q[k] <= crsf_rcd_pkg::MidValue;
      end
      hit_q <= '0;
    end else if (cmd_i.scan_step) begin
      hit_q[walk_q] <= hit_now;
      if (hit_now) begin
        reported_q[walk_q] <= cur_fresh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.walk_clr) begin
      walk_q <= '0;
    end else if (cmd_i.scan_step || cmd_i.walk_adv) begin
      walk_q <= sts_o.last_walk ? '0 : walk_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_chan_q <= 3'(walk_q);
      out_val_q  <= cur_fresh;
      out_last_q <= !higher_hit;
    end
  end

  assign res_valid_o = out_valid_q;
  assign channel_o   = out_chan_q;
  assign value_o     = out_val_q;
  assign last_o      = out_last_q;

endmodule

### src/crsf_rcd_ctrl.sv
// Controller: frame sequencing, change scan and report emission.
module crsf_rcd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  crsf_rcd_pkg::sts_t sts_i,
  output crsf_rcd_pkg::cmd_t cmd_o
);

  crsf_rcd_pkg::state_e state_q, state_d;
  logic beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crsf_rcd_pkg::StHunt;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    rx_ready_o = 1'b0;
    beat       = 1'b0;
    case (state_q)
      crsf_rcd_pkg::StHunt: begin
        rx_ready_o = 1'b1;
        beat       = rx_valid_i;
        if (beat && sts_i.is_sync) begin
          state_d = crsf_rcd_pkg::StLen;
        end
      end
      crsf_rcd_pkg::StLen: begin
        rx_ready_o = 1'b1;
        beat       = rx_valid_i;
        if (beat) begin
          if (sts_i.len_ok) begin
            cmd_o.start_frame = 1'b1;
            state_d           = crsf_rcd_pkg::StBody;
          end else begin
            state_d = crsf_rcd_pkg::StHunt;
          end
        end
      end
      crsf_rcd_pkg::StBody: begin
        rx_ready_o      = 1'b1;
        beat            = rx_valid_i;
        cmd_o.body_beat = beat;
        if (beat && sts_i.frame_end) begin
          if (sts_i.rc_ready) begin
            cmd_o.walk_clr = 1'b1;
            state_d        = crsf_rcd_pkg::StScan;
          end else begin
            state_d = crsf_rcd_pkg::StHunt;
          end
        end
      end
      crsf_rcd_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last_walk) begin
          state_d = crsf_rcd_pkg::StEmit;
        end
      end
      crsf_rcd_pkg::StEmit: begin
        if (!sts_i.hit_cur) begin
          cmd_o.walk_adv = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.walk_adv  = 1'b1;
          cmd_o.emit_load = 1'b1;
        end
        if (cmd_o.walk_adv && sts_i.last_walk) begin
          state_d = crsf_rcd_pkg::StHunt;
        end
      end
      default: begin
        state_d = crsf_rcd_pkg::StHunt;
      end
    endcase
  end

endmodule

### src/crsf_rc_channel_decoder.sv
// Top level of the CRSF RC channel decoder.
//
//   channel  | direction | handshake             | payload
//   rx       | in        | rx_valid_i/rx_ready_o | rx_byte_i
//   res      | out       | res_valid_o/res_ready_i | channel_o, value_o, last_o
//   dead_band| in        | dead_band_we_i        | dead_band_i
//
// One byte per cycle is taken while a frame is being received.
// After the last byte of a full RC frame the channel store is scanned, one
// channel a cycle, then walked again to emit a report for each channel that
// moved beyond the dead band; the walk waits while a report is not yet taken.
// Input is not taken during scan and emission. Reset clears all control
// state and sets every reported value to mid-range.
module crsf_rc_channel_decoder #(
  parameter int unsigned NumReported = crsf_rcd_pkg::NumReportedDef,
  parameter int unsigned MaxFrameLen = crsf_rcd_pkg::MaxFrameLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        dead_band_we_i,
  input  logic [12:0] dead_band_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  channel_o,
  output logic [10:0] value_o,
  output logic        last_o
);

  crsf_rcd_pkg::cmd_t cmd;
  crsf_rcd_pkg::sts_t sts;

  crsf_rcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crsf_rcd_dp #(
    .NumReported (NumReported),
    .MaxFrameLen (MaxFrameLen)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .dead_band_we_i (dead_band_we_i),
    .dead_band_i    (dead_band_i),
    .res_ready_i    (res_ready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_valid_o    (res_valid_o),
    .channel_o      (channel_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

endmodule
